FILE: hdl/pai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pareto archive package
// Types and constants shared by the Pareto front archive block.
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int unsigned RANK_BITS  = 6;
  localparam int unsigned COUNT_BITS = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_TEST   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_COPY,
    ST_PLACE,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                  nondom;
    logic                  inserted;
    logic                  refused;
    logic                  rvalid;
    logic [COUNT_BITS-1:0] removed;
    logic [COUNT_BITS-1:0] entry_count;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/pareto_archive_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pareto front archive with insert, test and read
// Keeps a two-objective front sorted by first, then second objective in one
// synchronous memory and updates it by scanning and shifting entries.
// ----------------------------------------------------------------------------
// The front lives in a single memory with one read and one write port, so
// every word is handled one entry per cycle. An insert scans from rank zero
// to the insertion position, counts the dominated entries after it, moves
// the tail of the table and writes the new point. A test word scans up to
// its insertion position, a read word reads the entry at its rank and an
// unused kind goes straight to its result. A finished result waits in an
// output register, so the next word is taken while the previous result is
// still stalled.
module pareto_archive_insert
  import pai_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [1:0]                  kind_i,
  input  wire  signed [VALUE_BITS-1:0] first_objective_i,
  input  wire  signed [VALUE_BITS-1:0] second_objective_i,
  input  wire  [RANK_BITS-1:0]        read_rank_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic                        nondominated_o,
  output logic                        was_inserted_o,
  output logic [COUNT_BITS-1:0]       removed_count_o,
  output logic [COUNT_BITS-1:0]       entry_count_o,
  output logic                        full_refused_o,
  output logic                        read_valid_o,
  output logic signed [VALUE_BITS-1:0] read_first_o,
  output logic signed [VALUE_BITS-1:0] read_second_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > RANK_BITS) ? CW : RANK_BITS;

  logic [2*VB-1:0] mem_q [CAPACITY];
  logic [2*VB-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [2*VB-1:0] mem_wdata;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic signed [VB-1:0]  p1_q, p1_d, p2_q, p2_d;
  logic signed [VB-1:0]  prev1_q, prev1_d, prev2_q, prev2_d;
  logic                  prev_vld_q, prev_vld_d;
  logic [RANK_BITS-1:0]  rank_q, rank_d;
  logic [CW-1:0]         size_q, size_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         src_q, src_d;
  logic [CW-1:0]         left_q, left_d;
  logic                  up_q, up_d;
  res_t                  res_q, res_d;
  res_t                  out_q, out_d;
  logic signed [VB-1:0]  rd1_q, rd1_d, rd2_q, rd2_d;
  logic signed [VB-1:0]  out1_q, out1_d, out2_q, out2_d;
  logic                  out_valid_q, out_valid_d;

  logic signed [VB-1:0]  e1, e2;
  logic                  e_below, e_equal, p_dom_e, prev_dom_p, at_end, rank_ok, ok;

  assign e1         = $signed(rdata_q[2*VB-1:VB]);
  assign e2         = $signed(rdata_q[VB-1:0]);
  assign e_below    = (e1 < p1_q) || ((e1 == p1_q) && (e2 < p2_q));
  assign e_equal    = (e1 == p1_q) && (e2 == p2_q);
  assign p_dom_e    = (p1_q <= e1) && (p2_q <= e2) && ((p1_q < e1) || (p2_q < e2));
  assign prev_dom_p = (prev1_q <= p1_q) && (prev2_q <= p2_q) &&
                      ((prev1_q < p1_q) || (prev2_q < p2_q));
  assign at_end     = (idx_q == size_q);
  assign rank_ok    = XW'(rank_q) < XW'(size_q);
  assign ok         = !(!at_end && e_equal) && !(prev_vld_q && prev_dom_p);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    prev1_d     = prev1_q;
    prev2_d     = prev2_q;
    prev_vld_d  = prev_vld_q;
    rank_d      = rank_q;
    size_d      = size_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    k_d         = k_q;
    src_d       = src_q;
    left_d      = left_q;
    up_d        = up_q;
    res_d       = res_q;
    out_d       = out_q;
    rd1_d       = rd1_q;
    rd2_d       = rd2_q;
    out1_d      = out1_q;
    out2_d      = out2_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q[AW-1:0];
    mem_wdata   = {p1_q, p2_q};
    mem_raddr   = AW'(idx_q + 1'b1);
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        mem_raddr = (kind_e'(kind_i) == KIND_READ) ? AW'(read_rank_i) : '0;
        if (in_valid_i) begin
          kind_d     = kind_e'(kind_i);
          p1_d       = first_objective_i;
          p2_d       = second_objective_i;
          rank_d     = read_rank_i;
          res_d      = '0;
          rd1_d      = '0;
          rd2_d      = '0;
          idx_d      = '0;
          prev_vld_d = 1'b0;
          k_d        = '0;
          case (kind_e'(kind_i))
            KIND_INSERT, KIND_TEST: state_d = ST_SCAN;
            KIND_READ:              state_d = ST_READ;
            default:                state_d = ST_FIN;
          endcase
        end
      end

      ST_SCAN: begin
        if (!at_end && e_below) begin
          prev1_d    = e1;
          prev2_d    = e2;
          prev_vld_d = 1'b1;
          idx_d      = idx_q + 1'b1;
        end else begin
          pos_d        = idx_q;
          res_d.nondom = ok;
          if (kind_q != KIND_INSERT || !ok) begin
            state_d = ST_FIN;
          end else if (size_q == CW'(CAPACITY)) begin
            res_d.refused = 1'b1;
            state_d       = ST_FIN;
          end else if (at_end) begin
            k_d     = '0;
            state_d = ST_PLACE;
          end else if (p_dom_e) begin
            k_d     = CW'(1);
            idx_d   = idx_q + 1'b1;
            state_d = ST_COUNT;
          end else begin
            k_d       = '0;
            up_d      = 1'b0;
            src_d     = size_q - 1'b1;
            left_d    = size_q - idx_q;
            mem_raddr = AW'(size_q - 1'b1);
            state_d   = ST_COPY;
          end
        end
      end

      ST_COUNT: begin
        if (!at_end && p_dom_e) begin
          k_d   = k_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end else if (at_end || k_q == CW'(1)) begin
          state_d = ST_PLACE;
        end else begin
          up_d      = 1'b1;
          src_d     = idx_q;
          left_d    = size_q - idx_q;
          mem_raddr = idx_q[AW-1:0];
          state_d   = ST_COPY;
        end
      end

      ST_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        mem_waddr = up_q ? AW'(src_q - (k_q - 1'b1)) : AW'(src_q + 1'b1);
        src_d     = up_q ? (src_q + 1'b1) : (src_q - 1'b1);
        mem_raddr = src_d[AW-1:0];
        left_d    = left_q - 1'b1;
        if (left_q == CW'(1)) begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        mem_we         = 1'b1;
        size_d         = CW'(size_q - k_q + 1'b1);
        res_d.inserted = 1'b1;
        res_d.removed  = COUNT_BITS'(k_q);
        state_d        = ST_FIN;
      end

      ST_READ: begin
        res_d.rvalid = rank_ok;
        rd1_d        = rank_ok ? e1 : '0;
        rd2_d        = rank_ok ? e2 : '0;
        state_d      = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d             = res_q;
          out_d.entry_count = COUNT_BITS'(size_q);
          out1_d            = rd1_q;
          out2_d            = rd2_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    prev1_q    <= prev1_d;
    prev2_q    <= prev2_d;
    prev_vld_q <= prev_vld_d;
    rank_q     <= rank_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    k_q        <= k_d;
    src_q      <= src_d;
    left_q     <= left_d;
    up_q       <= up_d;
    res_q      <= res_d;
    out_q      <= out_d;
    rd1_q      <= rd1_d;
    rd2_q      <= rd2_d;
    out1_q     <= out1_d;
    out2_q     <= out2_d;
  end

  assign out_valid_o       = out_valid_q;
  assign nondominated_o    = out_q.nondom;
  assign was_inserted_o    = out_q.inserted;
  assign removed_count_o   = out_q.removed;
  assign entry_count_o     = out_q.entry_count;
  assign full_refused_o    = out_q.refused;
  assign read_valid_o      = out_q.rvalid;
  assign read_first_o      = out1_q;
  assign read_second_o     = out2_q;

  // The table never grows beyond its capacity.
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The size changes only when a point is placed.
  a_size_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(size_q) |-> $past(state_q == ST_PLACE))
    else $error("entry count changed outside placement");

  // A move never writes the entry that it reads for the next step.
  a_copy_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && left_q != CW'(1)) |-> (mem_waddr != mem_raddr))
    else $error("table move overwrites an entry still to be read");

  // A new result appears only when an item finishes.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised without a finished word");

endmodule
`default_nettype wire
